FILE: sv/iep_pkg.sv
// ---------------------------------------------------------------------------
// iep_pkg
// shared constants, codes and helpers for the icmp echo ping engine
// ---------------------------------------------------------------------------
package iep_pkg;

    localparam int BUFFER_BYTES  = 256;
    localparam int REQUEST_BYTES = 32;

    localparam int REQ_IDX_W = $clog2(REQUEST_BYTES);
    localparam logic [REQ_IDX_W-1:0] REQ_LAST_IDX = REQ_IDX_W'(REQUEST_BYTES - 1);

    localparam logic [15:0] BUF_LIMIT = 16'(BUFFER_BYTES);

    // input commands
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_REQUEST = 2'd0;
    localparam logic [1:0] KIND_REPLY   = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_TARGET   = 2'd0;
    localparam logic [1:0] CFG_IDENT    = 2'd1;
    localparam logic [1:0] CFG_SEQUENCE = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT  = 2'd3;

    // parser status towards the top level
    typedef struct packed {
        logic frame_end;
        logic reply_match;
    } t_frame_status;

    // folded ones-complement sum of the fixed request words
    // (type/code word and payload words, checksum, ident and sequence as zero)
    function automatic logic [15:0] fixed_word_sum();
        logic [31:0] sum;
        logic [15:0] w;
        sum = 32'd0;
        for (int i = 0; i < REQUEST_BYTES; i += 2) begin
            w = 16'h0000;
            if (i == 0) begin
                w = 16'h0800;
            end else if (i >= 8) begin
                w[15:8] = 8'(i);
                if (i + 1 < REQUEST_BYTES) begin
                    w[7:0] = 8'(i + 1);
                end
            end
            sum = sum + {16'h0000, w};
        end
        for (int j = 0; j < 4; j++) begin
            sum = {16'h0000, sum[15:0]} + {16'h0000, sum[31:16]};
        end
        return sum[15:0];
    endfunction

    localparam logic [15:0] FIXED_SUM = fixed_word_sum();

    // end-around carry add of two 16-bit words
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // byte of the echo request at a given position
    function automatic logic [7:0] request_byte(
        input logic [REQ_IDX_W-1:0] idx,
        input logic [15:0]          csum,
        input logic [15:0]          ident,
        input logic [15:0]          seq
    );
        logic [7:0] b;
        b = 8'(idx);
        if (idx == REQ_IDX_W'(0))      b = 8'h08;
        else if (idx == REQ_IDX_W'(1)) b = 8'h00;
        else if (idx == REQ_IDX_W'(2)) b = csum[15:8];
        else if (idx == REQ_IDX_W'(3)) b = csum[7:0];
        else if (idx == REQ_IDX_W'(4)) b = ident[15:8];
        else if (idx == REQ_IDX_W'(5)) b = ident[7:0];
        else if (idx == REQ_IDX_W'(6)) b = seq[15:8];
        else if (idx == REQ_IDX_W'(7)) b = seq[7:0];
        return b;
    endfunction

endpackage

FILE: sv/icmp_echo_ping_engine_unit.sv
// ---------------------------------------------------------------------------
// icmp_echo_ping_engine_unit
// icmp echo request generator with reply matcher and millisecond timeout
// ---------------------------------------------------------------------------
// an accepted item puts its first result into the output register in the next cycle
// frame bytes and ticks are taken at one item per cycle while results drain and no request is being sent
// a start item closes the input while the byte sequencer sends the request, one request byte per
// cycle, when the output side takes one item a cycle
// reset: synchronous active low, clears the wait, the timer and the frame parser
// and loads the register defaults (ident 0xbeef, sequence 1, timeout 1000)
module icmp_echo_ping_engine_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic [1:0]  i_s_tuser,   // [1:0] command
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] tx_byte, [23:8] round_trip
    output logic [1:0]  o_m_tuser,   // [1:0] kind
    output logic        o_m_tlast,   // last request byte
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import iep_pkg::*;

    // configuration registers
    logic [31:0] r_target;
    logic [15:0] r_ident;
    logic [15:0] r_seq;
    logic [15:0] r_timeout;

    // ping state
    logic        r_waiting, n_waiting;
    logic [15:0] r_elapsed, n_elapsed;
    logic [15:0] elapsed_inc;

    // request byte sequencer
    logic                 r_tx_active, n_tx_active;
    logic [REQ_IDX_W-1:0] r_tx_idx, n_tx_idx;

    // output register
    logic        r_out_valid, n_out_valid;
    logic [1:0]  r_kind, n_kind;
    logic [7:0]  r_byte, n_byte;
    logic        r_last, n_last;
    logic [15:0] r_rt, n_rt;

    logic          out_free;
    logic          in_acc;
    logic          out_acc;
    logic [15:0]   csum;
    t_frame_status frame_st;

    // a new result may enter when the slot is empty or being emptied this cycle
    assign out_acc    = r_out_valid && i_m_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = out_free && !r_tx_active;
    assign in_acc     = i_s_tvalid && o_s_tready;

    // checksum: fixed words folded at elaboration, ident and sequence added here
    assign csum = ~oc_add(oc_add(FIXED_SUM, r_ident), r_seq);

    assign elapsed_inc = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;

    iep_frame_parser u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_byte_en        (in_acc && i_s_tuser == CMD_BYTE),
        .i_byte           (i_s_tdata),
        .i_target_address (r_target),
        .i_echo_ident     (r_ident),
        .i_echo_sequence  (r_seq),
        .o_status         (frame_st)
    );

    always_comb begin
        n_waiting   = r_waiting;
        n_elapsed   = r_elapsed;
        n_tx_active = r_tx_active;
        n_tx_idx    = r_tx_idx;
        n_out_valid = out_acc ? 1'b0 : r_out_valid;
        n_kind      = r_kind;
        n_byte      = r_byte;
        n_last      = r_last;
        n_rt        = r_rt;

        if (r_tx_active && out_acc) begin
            // next request byte follows the one just taken
            n_out_valid = 1'b1;
            n_kind      = KIND_REQUEST;
            n_byte      = request_byte(r_tx_idx, csum, r_ident, r_seq);
            n_last      = (r_tx_idx == REQ_LAST_IDX);
            n_rt        = 16'd0;
            if (r_tx_idx == REQ_LAST_IDX) begin
                n_tx_active = 1'b0;
            end else begin
                n_tx_idx = r_tx_idx + REQ_IDX_W'(1);
            end
        end else if (in_acc) begin
            case (i_s_tuser)
                CMD_START: begin
                    n_waiting   = 1'b1;
                    n_elapsed   = 16'd0;
                    n_out_valid = 1'b1;
                    n_kind      = KIND_REQUEST;
                    n_byte      = request_byte(REQ_IDX_W'(0), csum, r_ident, r_seq);
                    n_last      = (REQ_LAST_IDX == REQ_IDX_W'(0));
                    n_rt        = 16'd0;
                    n_tx_active = (REQ_LAST_IDX != REQ_IDX_W'(0));
                    n_tx_idx    = REQ_IDX_W'(1);
                end
                CMD_BYTE: begin
                    // reply counts only while a request is outstanding
                    if (frame_st.frame_end && frame_st.reply_match && r_waiting) begin
                        n_waiting   = 1'b0;
                        n_out_valid = 1'b1;
                        n_kind      = KIND_REPLY;
                        n_byte      = 8'h00;
                        n_last      = 1'b0;
                        n_rt        = r_elapsed;
                    end
                end
                CMD_TICK: begin
                    if (r_waiting) begin
                        n_elapsed = elapsed_inc;
                        if (elapsed_inc >= r_timeout) begin
                            n_waiting   = 1'b0;
                            n_out_valid = 1'b1;
                            n_kind      = KIND_TIMEOUT;
                            n_byte      = 8'h00;
                            n_last      = 1'b0;
                            n_rt        = 16'd0;
                        end
                    end
                end
                default: begin
                    // undefined command, dropped
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waiting   <= 1'b0;
            r_elapsed   <= 16'd0;
            r_tx_active <= 1'b0;
            r_tx_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_waiting   <= n_waiting;
            r_elapsed   <= n_elapsed;
            r_tx_active <= n_tx_active;
            r_tx_idx    <= n_tx_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_byte <= n_byte;
        r_last <= n_last;
        r_rt   <= n_rt;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= 32'd0;
            r_ident   <= 16'hBEEF;
            r_seq     <= 16'd1;
            r_timeout <= 16'd1000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TARGET:   r_target  <= i_cfg_data;
                CFG_IDENT:    r_ident   <= i_cfg_data[15:0];
                CFG_SEQUENCE: r_seq     <= i_cfg_data[15:0];
                CFG_TIMEOUT:  r_timeout <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_rt, r_byte};
    assign o_m_tuser  = r_kind;
    assign o_m_tlast  = r_last;

    // input stays closed while the request is being sent
    a_no_accept_during_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_active |-> !o_s_tready)
        else $error("input accepted during request transmission");

    // last flag only on request bytes
    a_last_is_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tuser == KIND_REQUEST))
        else $error("last flag on a non-request result");

    // the sequencer stops once the final byte is taken, unless a new start
    // is accepted in the same cycle
    a_tx_ends_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast && !(in_acc && i_s_tuser == CMD_START))
            |=> !r_tx_active)
        else $error("sequencer still busy after last request byte");

    // a start arms the wait and presents the first request byte
    a_start_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_s_tuser == CMD_START) |=>
            (r_waiting && o_m_tvalid && o_m_tuser == KIND_REQUEST))
        else $error("start did not arm the wait");

endmodule

FILE: sv/iep_frame_parser.sv
// ---------------------------------------------------------------------------
// iep_frame_parser
// walks received frame bytes and flags an echo reply from the target
// ---------------------------------------------------------------------------
module iep_frame_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_byte_en,
    input  logic [7:0]            i_byte,
    input  logic [31:0]           i_target_address,
    input  logic [15:0]           i_echo_ident,
    input  logic [15:0]           i_echo_sequence,
    output iep_pkg::t_frame_status o_status
);
    import iep_pkg::*;

    logic        r_in_data, n_in_data;
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_len, n_len;
    logic        r_src_ok, n_src_ok;
    logic [5:0]  r_off, n_off;
    logic        r_rep_ok, n_rep_ok;

    logic [15:0] eff;
    logic [7:0]  want_src;
    logic [7:0]  want_icmp;
    logic [5:0]  ihl;
    logic [16:0] d_rel;
    logic [2:0]  k;
    logic        in_hdr_win;
    logic        last_byte;

    assign eff = (r_len > BUF_LIMIT) ? BUF_LIMIT : r_len;
    assign ihl = {i_byte[3:0], 2'b00};

    always_comb begin
        n_in_data = r_in_data;
        n_pos     = r_pos;
        n_len     = r_len;
        n_src_ok  = r_src_ok;
        n_off     = r_off;
        n_rep_ok  = r_rep_ok;
        want_src  = 8'h00;
        want_icmp = i_byte;
        d_rel     = 17'd0;
        k         = 3'd0;
        in_hdr_win = 1'b0;
        last_byte = 1'b0;
        o_status  = '0;

        if (i_byte_en && !r_in_data) begin
            // address, port, length header
            case (r_pos[1:0])
                2'd0:    want_src = i_target_address[31:24];
                2'd1:    want_src = i_target_address[23:16];
                2'd2:    want_src = i_target_address[15:8];
                default: want_src = i_target_address[7:0];
            endcase
            if (r_pos < 16'd4) begin
                n_src_ok = ((r_pos == 16'd0) ? 1'b1 : r_src_ok) && (i_byte == want_src);
            end else if (r_pos == 16'd6) begin
                n_len = {i_byte, 8'h00};
            end else if (r_pos == 16'd7) begin
                n_len = {r_len[15:8], i_byte};
            end
            if (r_pos < 16'd7) begin
                n_pos = r_pos + 16'd1;
            end else begin
                n_pos     = 16'd0;
                n_rep_ok  = 1'b1;
                n_off     = 6'd0;
                n_in_data = ({r_len[15:8], i_byte} != 16'd0);
            end
        end else if (i_byte_en) begin
            // data phase
            if (r_pos < eff) begin
                if (r_pos == 16'd0) begin
                    n_off = 6'd0;
                    if (eff >= 16'd20 && i_byte[7:4] == 4'd4 && ihl >= 6'd20
                        && eff > {10'd0, ihl}) begin
                        n_off = ihl;
                    end
                end
                d_rel      = {1'b0, r_pos} - {11'd0, n_off};
                in_hdr_win = (r_pos >= {10'd0, n_off}) && (d_rel < 17'd8);
                k          = d_rel[2:0];
                if (in_hdr_win) begin
                    case (k)
                        3'd0, 3'd1: want_icmp = 8'h00;
                        3'd4:       want_icmp = i_echo_ident[15:8];
                        3'd5:       want_icmp = i_echo_ident[7:0];
                        3'd6:       want_icmp = i_echo_sequence[15:8];
                        3'd7:       want_icmp = i_echo_sequence[7:0];
                        default:    want_icmp = i_byte;
                    endcase
                    if (i_byte != want_icmp) n_rep_ok = 1'b0;
                end
            end
            last_byte = ({1'b0, r_pos} + 17'd1) >= {1'b0, r_len};
            if (last_byte) begin
                n_in_data = 1'b0;
                n_pos     = 16'd0;
                o_status.frame_end   = 1'b1;
                o_status.reply_match = r_src_ok && n_rep_ok
                                       && ({1'b0, eff} >= ({11'd0, n_off} + 17'd8));
            end else begin
                n_pos = r_pos + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_data <= 1'b0;
            r_pos     <= 16'd0;
            r_len     <= 16'd0;
            r_src_ok  <= 1'b0;
            r_off     <= 6'd0;
            r_rep_ok  <= 1'b1;
        end else begin
            r_in_data <= n_in_data;
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_src_ok  <= n_src_ok;
            r_off     <= n_off;
            r_rep_ok  <= n_rep_ok;
        end
    end

endmodule
